[rtl/llp_pkg.sv]
// ----------------------------------------------------------------------------
// llp_pkg
// Shared types and constants of the LL(1) predictive parser.
// ----------------------------------------------------------------------------
`default_nettype none

package llp_pkg;

	// grammar and stack sizes
	localparam int NONTERMINALS   = 16;
	localparam int TERMINALS      = 16;
	localparam int PRODUCTIONS    = 32;
	localparam int RHS_MAX        = 16;
	localparam int STACK_DEPTH    = 32;
	localparam int MAX_EXPANSIONS = 32;

	// table has one extra column for the end marker
	localparam int COLS    = TERMINALS + 1;
	localparam int TBL_DEPTH = NONTERMINALS * COLS;
	localparam int TBL_AW  = $clog2(TBL_DEPTH);
	localparam int SYM_DEPTH = PRODUCTIONS * RHS_MAX;
	localparam int SYM_AW  = $clog2(SYM_DEPTH);
	localparam int LEN_AW  = $clog2(PRODUCTIONS);
	localparam int STK_AW  = $clog2(STACK_DEPTH);

	// payload widths
	localparam int CMD_W  = 3;
	localparam int NT_W   = 4;
	localparam int TERM_W = 5;
	localparam int PROD_W = 5;
	localparam int POS_W  = 4;
	localparam int SYM_W  = 5;
	localparam int LEN_W  = 5;
	localparam int ACT_W  = 4;
	localparam int SP_W   = 6;
	localparam int EXP_W  = 6;
	localparam int CELL_W = PROD_W + 1;

	typedef enum logic [CMD_W-1:0] {
		CMD_CELL  = 3'd0,
		CMD_SYM   = 3'd1,
		CMD_LEN   = 3'd2,
		CMD_START = 3'd3,
		CMD_TOKEN = 3'd4
	} cmd_t;

	typedef enum logic [ACT_W-1:0] {
		ACT_LOADED   = 4'd0,
		ACT_MATCH    = 4'd1,
		ACT_APPLY    = 4'd2,
		ACT_ACCEPT   = 4'd3,
		ACT_NORULE   = 4'd4,
		ACT_MISMATCH = 4'd5,
		ACT_OVERFLOW = 4'd6,
		ACT_LIMIT    = 4'd7,
		ACT_INACTIVE = 4'd8
	} act_t;

	typedef struct packed {
		logic [LEN_W-1:0]  rhs_length;
		logic [SYM_W-1:0]  symbol;
		logic [POS_W-1:0]  position;
		logic              cell_valid;
		logic [PROD_W-1:0] production_number;
		logic [TERM_W-1:0] terminal_index;
		logic [NT_W-1:0]   nonterminal_index;
		logic [CMD_W-1:0]  command;
	} item_t;

	typedef struct packed {
		logic              last;
		logic [SP_W-1:0]   stack_depth;
		logic [PROD_W-1:0] applied_production;
		logic [TERM_W-1:0] token_terminal;
		logic [NT_W-1:0]   top_nonterminal;
		logic [ACT_W-1:0]  action;
	} result_t;

endpackage

`default_nettype wire

[rtl/llp_ram.sv]
// ----------------------------------------------------------------------------
// llp_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module llp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read; read data holds between reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/llp_core.sv]
// ----------------------------------------------------------------------------
// llp_core
// Parser sequencer: table loads, stack expansion and matching over the
// table, production and stack memories, with one result register.
// ----------------------------------------------------------------------------
`default_nettype none

module llp_core (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic [llp_pkg::NT_W-1:0] start_nt,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire llp_pkg::item_t           in_item,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output llp_pkg::result_t              out_res
);

	import llp_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_DISP, S_CHECK, S_TOP, S_CELL, S_LEN, S_PUSH, S_APPLY, S_FINAL
	} state_t;

	state_t              state_q;
	logic [TBL_AW-1:0]   clr_q;
	item_t               item_q;
	logic [SP_W-1:0]     sp_q;
	logic                active_q;
	logic [EXP_W-1:0]    exp_q;
	logic [NT_W-1:0]     nt_q;
	logic [PROD_W-1:0]   prod_q;
	logic [LEN_W-1:0]    cnt_q;
	act_t                fin_act_q;
	logic [NT_W-1:0]     fin_nt_q;
	logic [PROD_W-1:0]   fin_prod_q;

	// memory ports
	logic                tbl_we, tbl_re;
	logic [TBL_AW-1:0]   tbl_waddr, tbl_raddr;
	logic [CELL_W-1:0]   tbl_wdata, tbl_rdata;
	logic                sym_we, sym_re;
	logic [SYM_AW-1:0]   sym_waddr, sym_raddr;
	logic [SYM_W-1:0]    sym_rdata;
	logic                len_we, len_re;
	logic [LEN_AW-1:0]   len_waddr, len_raddr;
	logic [LEN_W-1:0]    len_wdata, len_rdata;
	logic                stk_we, stk_re;
	logic [STK_AW-1:0]   stk_waddr, stk_raddr;
	logic [SYM_W-1:0]    stk_wdata, stk_rdata;

	logic                slot_free;
	logic [TBL_AW-1:0]   load_cell_addr, tok_cell_addr;
	logic [SYM_AW-1:0]   prod_base;
	logic [LEN_W-1:0]    len_eff;
	logic [SP_W:0]       new_sp;
	logic                top_is_nt, top_in_range;

	assign slot_free = !out_valid || out_ready;
	assign in_ready  = (state_q == S_IDLE);

	assign load_cell_addr = TBL_AW'(item_q.nonterminal_index) * TBL_AW'(COLS)
		+ TBL_AW'(item_q.terminal_index);
	assign tok_cell_addr = TBL_AW'(stk_rdata[NT_W-1:0]) * TBL_AW'(COLS)
		+ TBL_AW'(item_q.terminal_index);
	assign prod_base = SYM_AW'(prod_q) * SYM_AW'(RHS_MAX);

	// effective production length, saturated; zero for a production out of range
	always_comb begin
		len_eff = '0;
		if (prod_q < PRODUCTIONS) begin
			len_eff = (len_rdata > LEN_W'(RHS_MAX)) ? LEN_W'(RHS_MAX) : len_rdata;
		end
	end
	assign new_sp = {1'b0, sp_q} - (SP_W+1)'(1) + (SP_W+1)'(len_eff);

	assign top_is_nt    = stk_rdata[SYM_W-1];
	assign top_in_range = (stk_rdata[NT_W-1:0] < NONTERMINALS)
		&& (item_q.terminal_index <= TERMINALS);

	// memory controls
	always_comb begin
		tbl_we = 1'b0; tbl_waddr = clr_q; tbl_wdata = '0;
		tbl_re = 1'b0; tbl_raddr = tok_cell_addr;
		sym_we = 1'b0;
		sym_waddr = SYM_AW'(item_q.production_number) * SYM_AW'(RHS_MAX)
			+ SYM_AW'(item_q.position);
		sym_re = 1'b0; sym_raddr = prod_base + SYM_AW'(len_eff) - SYM_AW'(1);
		len_we = 1'b0; len_waddr = LEN_AW'(item_q.production_number);
		len_wdata = (item_q.rhs_length > LEN_W'(RHS_MAX)) ? LEN_W'(RHS_MAX)
			: item_q.rhs_length;
		len_re = 1'b0; len_raddr = LEN_AW'(prod_q);
		stk_we = 1'b0; stk_waddr = STK_AW'(sp_q); stk_wdata = sym_rdata;
		stk_re = 1'b0; stk_raddr = STK_AW'(sp_q - SP_W'(1));
		unique case (state_q)
			S_CLEAR: begin
				tbl_we = 1'b1;
			end
			S_DISP: begin
				if (slot_free) begin
					case (item_q.command)
						CMD_CELL: begin
							if (item_q.nonterminal_index < NONTERMINALS
								&& item_q.terminal_index <= TERMINALS
								&& (!item_q.cell_valid
								|| item_q.production_number < PRODUCTIONS)) begin
								tbl_we    = 1'b1;
								tbl_waddr = load_cell_addr;
								tbl_wdata = item_q.cell_valid
									? {1'b1, item_q.production_number} : '0;
							end
						end
						CMD_SYM: begin
							sym_we = (item_q.production_number < PRODUCTIONS)
								&& (item_q.position < RHS_MAX);
						end
						CMD_LEN: begin
							len_we = (item_q.production_number < PRODUCTIONS);
						end
						CMD_START: begin
							stk_we    = 1'b1;
							stk_waddr = '0;
							stk_wdata = {1'b1, start_nt};
						end
						default: ;
					endcase
				end
			end
			S_CHECK: begin
				stk_re = (sp_q != '0);
			end
			S_TOP: begin
				tbl_re = top_is_nt && top_in_range;
			end
			S_CELL: begin
				// address the length by the production just read from the table
				len_re    = tbl_rdata[CELL_W-1] && (exp_q < MAX_EXPANSIONS);
				len_raddr = LEN_AW'(tbl_rdata[PROD_W-1:0]);
			end
			S_LEN: begin
				sym_re = (new_sp <= (SP_W+1)'(STACK_DEPTH)) && (len_eff != '0);
			end
			S_PUSH: begin
				stk_we    = 1'b1;
				sym_re    = (cnt_q > LEN_W'(1));
				sym_raddr = prod_base + SYM_AW'(cnt_q) - SYM_AW'(2);
			end
			default: ;
		endcase
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			sp_q      <= '0;
			active_q  <= 1'b0;
			exp_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + TBL_AW'(1);
					if (clr_q == TBL_AW'(TBL_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						item_q  <= in_item;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					if (item_q.command == CMD_TOKEN && active_q) begin
						exp_q   <= '0;
						state_q <= S_CHECK;
					end else if (slot_free) begin
						out_valid <= 1'b1;
						case (item_q.command)
							CMD_CELL, CMD_SYM, CMD_LEN: begin
								out_res <= '{last: 1'b1, stack_depth: sp_q,
									applied_production: '0, token_terminal: '0,
									top_nonterminal: '0, action: ACT_LOADED};
							end
							CMD_START: begin
								sp_q     <= SP_W'(1);
								active_q <= 1'b1;
								out_res  <= '{last: 1'b1, stack_depth: SP_W'(1),
									applied_production: '0, token_terminal: '0,
									top_nonterminal: '0, action: ACT_LOADED};
							end
							CMD_TOKEN: begin
								out_res <= '{last: 1'b1, stack_depth: sp_q,
									applied_production: '0,
									token_terminal: item_q.terminal_index,
									top_nonterminal: '0, action: ACT_INACTIVE};
							end
							default: begin
								out_res <= '{last: 1'b1, stack_depth: sp_q,
									applied_production: '0, token_terminal: '0,
									top_nonterminal: '0, action: ACT_INACTIVE};
							end
						endcase
						state_q <= S_IDLE;
					end
				end
				S_CHECK: begin
					fin_nt_q   <= '0;
					fin_prod_q <= '0;
					if (sp_q == '0) begin
						fin_act_q <= (item_q.terminal_index == TERM_W'(TERMINALS))
							? ACT_ACCEPT : ACT_MISMATCH;
						active_q  <= 1'b0;
						state_q   <= S_FINAL;
					end else begin
						state_q <= S_TOP;
					end
				end
				S_TOP: begin
					nt_q <= stk_rdata[NT_W-1:0];
					if (!top_is_nt) begin
						if (item_q.terminal_index < TERMINALS
							&& item_q.terminal_index[NT_W-1:0] == stk_rdata[NT_W-1:0]) begin
							fin_act_q <= ACT_MATCH;
							sp_q      <= sp_q - SP_W'(1);
						end else begin
							fin_act_q <= ACT_MISMATCH;
							active_q  <= 1'b0;
						end
						state_q <= S_FINAL;
					end else if (!top_in_range) begin
						fin_act_q <= ACT_NORULE;
						fin_nt_q  <= stk_rdata[NT_W-1:0];
						active_q  <= 1'b0;
						state_q   <= S_FINAL;
					end else begin
						state_q <= S_CELL;
					end
				end
				S_CELL: begin
					prod_q <= tbl_rdata[PROD_W-1:0];
					if (!tbl_rdata[CELL_W-1]) begin
						fin_act_q <= ACT_NORULE;
						fin_nt_q  <= nt_q;
						active_q  <= 1'b0;
						state_q   <= S_FINAL;
					end else if (exp_q >= MAX_EXPANSIONS) begin
						fin_act_q <= ACT_LIMIT;
						fin_nt_q  <= nt_q;
						active_q  <= 1'b0;
						state_q   <= S_FINAL;
					end else begin
						state_q <= S_LEN;
					end
				end
				S_LEN: begin
					if (new_sp > (SP_W+1)'(STACK_DEPTH)) begin
						fin_act_q  <= ACT_OVERFLOW;
						fin_nt_q   <= nt_q;
						fin_prod_q <= prod_q;
						active_q   <= 1'b0;
						state_q    <= S_FINAL;
					end else begin
						sp_q    <= sp_q - SP_W'(1);
						cnt_q   <= len_eff;
						state_q <= (len_eff == '0) ? S_APPLY : S_PUSH;
					end
				end
				S_PUSH: begin
					sp_q  <= sp_q + SP_W'(1);
					cnt_q <= cnt_q - LEN_W'(1);
					if (cnt_q == LEN_W'(1)) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					if (slot_free) begin
						out_valid <= 1'b1;
						out_res   <= '{last: 1'b0, stack_depth: sp_q,
							applied_production: prod_q,
							token_terminal: item_q.terminal_index,
							top_nonterminal: nt_q, action: ACT_APPLY};
						exp_q   <= exp_q + EXP_W'(1);
						state_q <= S_CHECK;
					end
				end
				S_FINAL: begin
					if (slot_free) begin
						out_valid <= 1'b1;
						out_res   <= '{last: 1'b1, stack_depth: sp_q,
							applied_production: fin_prod_q,
							token_terminal: item_q.terminal_index,
							top_nonterminal: fin_nt_q, action: fin_act_q};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	llp_ram #(.WIDTH(CELL_W), .DEPTH(TBL_DEPTH)) u_tbl (
		.clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
		.re(tbl_re), .raddr(tbl_raddr), .rdata(tbl_rdata)
	);

	llp_ram #(.WIDTH(SYM_W), .DEPTH(SYM_DEPTH)) u_sym (
		.clk(clk), .we(sym_we), .waddr(sym_waddr), .wdata(item_q.symbol),
		.re(sym_re), .raddr(sym_raddr), .rdata(sym_rdata)
	);

	llp_ram #(.WIDTH(LEN_W), .DEPTH(PRODUCTIONS)) u_len (
		.clk(clk), .we(len_we), .waddr(len_waddr), .wdata(len_wdata),
		.re(len_re), .raddr(len_raddr), .rdata(len_rdata)
	);

	llp_ram #(.WIDTH(SYM_W), .DEPTH(STACK_DEPTH)) u_stk (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.re(stk_re), .raddr(stk_raddr), .rdata(stk_rdata)
	);

endmodule

`default_nettype wire

[rtl/ll1_table_driven_parser_unit.sv]
// Load and start commands: the request is registered, then written as a result.
// Token: a dispatch step, then per applied production of length L the states check,
// top, cell, length, L pushes (one stack push a cycle through the symbol memory) and
// apply, then check and up to top, cell and length for the closing match, accept or
// error. One request is worked on at a time; the next is taken while a result waits.
// After reset the parse table is swept clear, all 272 cells; no request is taken.
// ----------------------------------------------------------------------------
// ll1_table_driven_parser_unit
// Table-driven LL(1) predictive parser with stream ports and an APB register.
// ----------------------------------------------------------------------------
`default_nettype none

module ll1_table_driven_parser_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// requests
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// command[2:0], nonterminal_index[6:3], terminal_index[11:7],
	// production_number[16:12], cell_valid[17], position[21:18],
	// symbol[26:22], rhs_length[31:27]
	input  wire logic [31:0] s_axis_tdata,
	// results
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// action[3:0], top_nonterminal[7:4], token_terminal[12:8],
	// applied_production[17:13], stack_depth[23:18]
	output logic      [23:0] m_axis_tdata,
	output logic             m_axis_tlast
);

	import llp_pkg::*;

	logic [NT_W-1:0] start_nt_q;
	result_t         res;

	// start nonterminal register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_nt_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
			start_nt_q <= pwdata[NT_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {{(32-NT_W){1'b0}}, start_nt_q} : '0;

	llp_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.start_nt (start_nt_q),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (item_t'(s_axis_tdata)),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_res  (res)
	);

	assign m_axis_tdata = {res.stack_depth, res.applied_production, res.token_terminal,
		res.top_nonterminal, res.action};
	assign m_axis_tlast = res.last;

endmodule

`default_nettype wire
